>>> hdl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Plain concurrent checks on a clock with a synchronous reset as disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/tcst_pkg.sv
// Types, codes and helpers for the text cursor seek tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcst_pkg;

  typedef enum logic [1:0] {
    MODE_STEP    = 2'd0,
    MODE_LOAD    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_POS         = 3'd0,
    KIND_WRAP_NEAR   = 3'd1,
    KIND_WRAP_DOWN   = 3'd2,
    KIND_UNWRAP_NEAR = 3'd3,
    KIND_UNWRAP_DOWN = 3'd4,
    KIND_LINE_COL    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    REG_SEEK_KIND   = 3'd0,
    REG_SEEK_INDEX  = 3'd1,
    REG_SEEK_COLUMN = 3'd2,
    REG_SEEK_X      = 3'd3,
    REG_SEEK_Y      = 3'd4,
    REG_WRAP_WIDTH  = 3'd5,
    REG_LINE_HEIGHT = 3'd6,
    REG_TEXT_LENGTH = 3'd7
  } reg_idx_t;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;

  localparam logic [15:0] LINE_HEIGHT_RESET = 16'd256;

  typedef struct packed {
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] ux;
    logic [31:0] uy;
  } coord_t;

  typedef struct packed {
    logic [2:0]  seek_kind;
    logic [23:0] seek_index;
    logic [23:0] seek_column;
    logic [31:0] seek_x;
    logic [31:0] seek_y;
    logic [31:0] wrap_width;
    logic [15:0] line_height;
    logic [23:0] text_length;
  } seek_cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        is_nl;
    logic [16:0] width;
  } item_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/tcst_in_stage.sv
// Input register and advance-width memory of the tracker.
// Depends on tcst_pkg; presents the registered transaction with its width.
`default_nettype none

module tcst_in_stage #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [1:0]    mode,
  input  wire logic [7:0]    ch,
  input  wire logic [15:0]   advance_value,
  output tcst_pkg::item_t    item
);
  import tcst_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);

  logic [15:0]              mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld;
  logic [AW-1:0]            addr;
  logic                     in_range;
  logic                     load_we;

  logic [15:0] sh_bs;
  logic [15:0] sh_r;
  logic [15:0] rdata;
  logic        rd_ok;
  logic [1:0]  s_mode;
  logic        s_nl;
  logic        s_cr;

  assign addr     = ch[AW-1:0];
  assign in_range = {1'b0, ch} < 9'(TABLE_ENTRIES);
  assign load_we  = accept && (mode == MODE_LOAD) && in_range;

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[addr] <= advance_value;
    end
    if (accept) begin
      rdata  <= mem[addr];
      s_mode <= mode;
      s_nl   <= (ch == CH_NEWLINE);
      s_cr   <= (ch == CH_CR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      sh_bs <= '0;
      sh_r  <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (accept) begin
        rd_ok <= in_range && vld[addr];
      end
      if (load_we) begin
        vld[addr] <= 1'b1;
        if (ch == CH_BACKSLASH) begin
          sh_bs <= advance_value;
        end
        if (ch == CH_LOWER_R) begin
          sh_r <= advance_value;
        end
      end
    end
  end

  always_comb begin
    item.mode  = s_mode;
    item.is_nl = s_nl;
    if (s_cr) begin
      item.width = {1'b0, sh_bs} + {1'b0, sh_r};
    end else if (rd_ok) begin
      item.width = {1'b0, rdata};
    end else begin
      item.width = '0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tcst_walk.sv
// Next-cursor logic for one character step of the tracker.
// Depends on tcst_pkg; purely combinational between the input and cursor registers.
`default_nettype none

module tcst_walk #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic [POSITION_BITS-1:0] pos,
  input  wire logic [POSITION_BITS-1:0] line,
  input  wire logic [POSITION_BITS-1:0] col,
  input  tcst_pkg::coord_t              crd,
  input  tcst_pkg::item_t               item,
  input  tcst_pkg::seek_cfg_t           cfg,
  output logic [POSITION_BITS-1:0]      pos_next,
  output logic [POSITION_BITS-1:0]      line_next,
  output logic [POSITION_BITS-1:0]      col_next,
  output tcst_pkg::coord_t              crd_next,
  output logic                          stop
);
  import tcst_pkg::*;

  localparam int CW = (POSITION_BITS > 24) ? POSITION_BITS : 24;
  localparam logic [POSITION_BITS-1:0] CntMax = '1;

  logic [POSITION_BITS-1:0] pos_inc, line_inc, col_inc;
  logic [POSITION_BITS-1:0] line_c, col_c, prev_col;
  logic [31:0] lh32, w32, wy_lh;
  logic        wrap;
  coord_t      cur, prev;
  logic        is_xy, is_wrapped, nearest;
  logic [31:0] x, px, y;
  logic        take_prev;

  assign pos_inc  = (pos == CntMax) ? pos : pos + POSITION_BITS'(1);
  assign line_inc = (line == CntMax) ? line : line + POSITION_BITS'(1);
  assign col_inc  = (col == CntMax) ? col : col + POSITION_BITS'(1);

  assign lh32  = {16'b0, cfg.line_height};
  assign w32   = {15'b0, item.width};
  assign wy_lh = sat_add(crd.wy, lh32);
  assign wrap  = ({1'b0, crd.wx} + {16'b0, item.width}) >= {1'b0, cfg.wrap_width};

  always_comb begin
    if (item.is_nl) begin
      line_c   = line_inc;
      col_c    = POSITION_BITS'(1);
      cur.wx   = '0;
      cur.wy   = wy_lh;
      cur.ux   = '0;
      cur.uy   = sat_add(crd.uy, lh32);
      prev     = crd;
      prev_col = col;
    end else begin
      line_c   = line;
      col_c    = col_inc;
      cur.wx   = wrap ? w32 : sat_add(crd.wx, w32);
      cur.wy   = wrap ? wy_lh : crd.wy;
      cur.ux   = sat_add(crd.ux, w32);
      cur.uy   = crd.uy;
      prev.wx  = wrap ? 32'd0 : crd.wx;
      prev.wy  = cur.wy;
      prev.ux  = crd.ux;
      prev.uy  = crd.uy;
      prev_col = wrap ? col_inc : col;
    end
  end

  assign is_wrapped = (cfg.seek_kind == KIND_WRAP_NEAR) || (cfg.seek_kind == KIND_WRAP_DOWN);
  assign is_xy      = is_wrapped || (cfg.seek_kind == KIND_UNWRAP_NEAR)
                      || (cfg.seek_kind == KIND_UNWRAP_DOWN);
  assign nearest    = (cfg.seek_kind == KIND_WRAP_NEAR) || (cfg.seek_kind == KIND_UNWRAP_NEAR);
  assign x          = is_wrapped ? cur.wx : cur.ux;
  assign px         = is_wrapped ? prev.wx : prev.ux;
  assign y          = is_wrapped ? cur.wy : cur.uy;

  always_comb begin
    stop      = 1'b0;
    take_prev = 1'b0;
    if (CW'(pos_inc) > CW'(cfg.text_length)) begin
      stop      = 1'b1;
      take_prev = 1'b1;
    end else if (is_xy) begin
      if (y > cfg.seek_y) begin
        stop      = 1'b1;
        take_prev = 1'b1;
      end else if ((({1'b0, y} + {17'b0, cfg.line_height}) > {1'b0, cfg.seek_y})
                   && (x >= cfg.seek_x)) begin
        if (nearest) begin
          stop      = 1'b1;
          take_prev = !item.is_nl
                      && ({1'b0, cfg.seek_x, 1'b0} < ({2'b0, x} + {2'b0, px}));
        end else if (x > cfg.seek_x) begin
          stop      = 1'b1;
          take_prev = 1'b1;
        end
      end
    end else begin
      case (cfg.seek_kind)
        KIND_POS: begin
          if (CW'(pos_inc) > CW'(cfg.seek_index)) begin
            stop      = 1'b1;
            take_prev = 1'b1;
          end
        end
        KIND_LINE_COL: begin
          if ((CW'(line_c) == CW'(cfg.seek_index)) && (CW'(col_c) >= CW'(cfg.seek_column))) begin
            stop = 1'b1;
          end else if (CW'(line_c) > CW'(cfg.seek_index)) begin
            stop      = 1'b1;
            take_prev = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (take_prev) begin
      pos_next  = pos;
      line_next = line;
      col_next  = prev_col;
      crd_next  = prev;
    end else begin
      pos_next  = pos_inc;
      line_next = line_c;
      col_next  = col_c;
      crd_next  = cur;
    end
  end

endmodule

`default_nettype wire

>>> hdl/text_cursor_seek_tracker.sv
// Top level of the text cursor seek tracker: handshake, config registers, cursor state.
// Depends on tcst_pkg, tcst_in_stage, tcst_walk and assert_macros.svh.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_ready, mode, ch, advance_value    | in
//   out     | out_valid, out_ready, stopped, cur_*, *_out    | out
//   cfg     | cfg_write, cfg_index, cfg_data                 | in
//
// Each transaction passes through the input register with the advance memory read,
// then the cursor update into the cursor/result registers.
// One transaction per cycle when unstalled; the cursor feedback loop sets the clock.
// Reset restarts the cursor, clears the halt flag and table valid bits, resets config.
// A stalled output holds the result; one more transaction waits in the input register.
`default_nettype none
`include "assert_macros.svh"

module text_cursor_seek_tracker #(
  parameter int TABLE_ENTRIES = 256,
  parameter int POSITION_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  ch,
  input  wire logic [15:0] advance_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             stopped,
  output logic [23:0]      cur_pos,
  output logic [23:0]      cur_line,
  output logic [23:0]      cur_column,
  output logic [31:0]      wrapped_x_out,
  output logic [31:0]      wrapped_y_out,
  output logic [31:0]      unwrapped_x_out,
  output logic [31:0]      unwrapped_y_out,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import tcst_pkg::*;

  seek_cfg_t cfg;
  item_t     item;
  logic      s1_valid;
  logic      accept;
  logic      fire;

  logic [POSITION_BITS-1:0] pos, line, col;
  logic [POSITION_BITS-1:0] pos_next, line_next, col_next;
  coord_t                   crd, crd_next;
  logic                     halted;
  logic                     stop;

  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{seek_kind: '0, seek_index: '0, seek_column: '0, seek_x: '0, seek_y: '0,
               wrap_width: '0, line_height: LINE_HEIGHT_RESET, text_length: '0};
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SEEK_KIND:   cfg.seek_kind   <= cfg_data[2:0];
        REG_SEEK_INDEX:  cfg.seek_index  <= cfg_data[23:0];
        REG_SEEK_COLUMN: cfg.seek_column <= cfg_data[23:0];
        REG_SEEK_X:      cfg.seek_x      <= cfg_data;
        REG_SEEK_Y:      cfg.seek_y      <= cfg_data;
        REG_WRAP_WIDTH:  cfg.wrap_width  <= cfg_data;
        REG_LINE_HEIGHT: cfg.line_height <= cfg_data[15:0];
        REG_TEXT_LENGTH: cfg.text_length <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  tcst_in_stage #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_in_stage (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mode         (mode),
    .ch           (ch),
    .advance_value(advance_value),
    .item         (item)
  );

  tcst_walk #(
    .POSITION_BITS(POSITION_BITS)
  ) u_walk (
    .pos      (pos),
    .line     (line),
    .col      (col),
    .crd      (crd),
    .item     (item),
    .cfg      (cfg),
    .pos_next (pos_next),
    .line_next(line_next),
    .col_next (col_next),
    .crd_next (crd_next),
    .stop     (stop)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      line   <= POSITION_BITS'(1);
      col    <= POSITION_BITS'(1);
      crd    <= '0;
      halted <= 1'b0;
    end else if (fire) begin
      case (item.mode)
        MODE_STEP: begin
          if (!halted) begin
            pos    <= pos_next;
            line   <= line_next;
            col    <= col_next;
            crd    <= crd_next;
            halted <= stop;
          end
        end
        MODE_RESTART: begin
          pos    <= '0;
          line   <= POSITION_BITS'(1);
          col    <= POSITION_BITS'(1);
          crd    <= '0;
          halted <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign stopped         = halted;
  assign cur_pos         = 24'(pos);
  assign cur_line        = 24'(line);
  assign cur_column      = 24'(col);
  assign wrapped_x_out   = crd.wx;
  assign wrapped_y_out   = crd.wy;
  assign unwrapped_x_out = crd.ux;
  assign unwrapped_y_out = crd.uy;

  `ASSERT_NEXT(a_halt_holds, clk, rst, halted && !(fire && (item.mode == MODE_RESTART)), halted)
  `ASSERT_NEXT(a_cursor_frozen, clk, rst, halted && !(fire && (item.mode == MODE_RESTART)), $stable(pos) && $stable(crd))
  `ASSERT_IMPLIES(a_full_stall, clk, rst, s1_valid && out_valid && !out_ready, !in_ready)
  `ASSERT_IMPLIES(a_result_source, clk, rst, $rose(out_valid), $past(fire))

endmodule

`default_nettype wire
